// ===== src/wom_pkg.sv =====
package wom_pkg;

   localparam int SINE_ENTRIES = 256;
   localparam int SINE_IDX_W = 8;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int DIV_W = 40;
   localparam int RATE_W = 18;

   typedef logic [14:0] qtab_type [0:SINE_ENTRIES];

   typedef enum logic [2:0] {
      CSR_WAVEFORM     = 3'd0,
      CSR_SAMPLE_RATE  = 3'd1,
      CSR_TONE_FREQ    = 3'd2,
      CSR_PHASE_OFFSET = 3'd3,
      CSR_START_OFFSET = 3'd4,
      CSR_VOLUME       = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SQUARE   = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      DIV_SEED = 2'd0,
      DIV_PMOD = 2'd1,
      DIV_STEP = 2'd2,
      DIV_WAVE = 2'd3
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_GO,
      ST_SEED_WAIT,
      ST_PMOD_GO,
      ST_PMOD_WAIT,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_WAVE_GO,
      ST_WAVE_WAIT,
      ST_SHAPE,
      ST_MUL1,
      ST_MUL2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       seed_mul;
      logic       div_start;
      div_op_type div_op;
      logic       div_load;
      logic       shape;
      logic       mul1;
      logic       mul2;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic needs_seed;
      logic out_free;
   } status_type;

   function automatic qtab_type build_qtab();
      qtab_type t;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] v;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         z = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
         z2 = (z * z) >> 30;
         term = z;
         sum = signed'(z);
         for (int n = 1; n <= 5; n++) begin
            term = (term * z2) >> 30;
            case (n)
               1: term = term / 64'd6;
               2: term = term / 64'd20;
               3: term = term / 64'd42;
               4: term = term / 64'd72;
               default: term = term / 64'd110;
            endcase
            if (n % 2 == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         t[k] = v[14:0];
      end
      return t;
   endfunction

endpackage

// ===== src/wom_div.sv =====
module wom_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wom_pkg::DIV_W-1:0]  num,
   input  logic [5:0]                 bits,
   input  logic [wom_pkg::RATE_W-1:0] den,
   output logic                       done,
   output logic [wom_pkg::DIV_W-1:0]  quo,
   output logic [wom_pkg::RATE_W-1:0] rem
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic [wom_pkg::DIV_W-1:0]  num_ff, num_in;
   logic [wom_pkg::RATE_W-1:0] rem_ff, rem_in;
   logic [wom_pkg::RATE_W:0]   trial;
   logic                       ge;

   assign trial = {rem_ff, num_ff[wom_pkg::DIV_W-1]};
   assign ge = trial >= {1'b0, den};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = bits;
         num_in = num;
         rem_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? wom_pkg::RATE_W'(trial - {1'b0, den}) : trial[wom_pkg::RATE_W-1:0];
         num_in = {num_ff[wom_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quo = num_ff;
   assign rem = rem_ff;

endmodule

// ===== src/wom_datapath.sv =====
module wom_datapath #(
   parameter int AMPLITUDE_SCALE = 32000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [19:0]         csr_data,
   input  logic signed [15:0]  req_mix_sample,
   input  logic                req_last_of_block,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_out_sample,
   output logic                rsp_out_last,
   input  wom_pkg::cmd_type    cmd,
   output wom_pkg::status_type status
);

   localparam logic [14:0] SCALE = 15'(AMPLITUDE_SCALE);
   localparam wom_pkg::qtab_type QTAB = wom_pkg::build_qtab();

   logic [1:0]  waveform_ff;
   logic [17:0] sample_rate_ff;
   logic [16:0] tone_freq_ff;
   logic [19:0] phase_offset_ff;
   logic [19:0] start_offset_ff;
   logic [14:0] volume_ff;

   logic [17:0]        acc_ff, acc_in;
   logic               needs_seed_ff;
   logic signed [15:0] mix_ff;
   logic               last_ff;
   logic [37:0]        seed_prod_ff;
   logic [17:0]        p_ff;
   logic [16:0]        step_ff;
   logic [16:0]        q_ff;
   logic [15:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [14:0]        tab_ff;
   logic [30:0]        mul1_ff;
   logic [45:0]        mul2_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] out_sample_ff;
   logic               out_last_ff;

   logic [17:0]                rate;
   logic [wom_pkg::DIV_W-1:0]  div_num;
   logic [5:0]                 div_bits;
   logic                       div_done;
   logic [wom_pkg::DIV_W-1:0]  div_quo;
   logic [17:0]                div_rem;
   logic [9:0]                 sine_idx;
   logic [8:0]                 tab_addr;
   logic [15:0]                saw_q;
   logic [15:0]                mag_sel;
   logic [16:0]                amp_mag;
   logic signed [17:0]         amp;
   logic [18:0]                next_p;

   assign rate = (sample_rate_ff == 18'd0) ? 18'd1 : sample_rate_ff;

   always_comb begin
      case (cmd.div_op)
         wom_pkg::DIV_SEED: begin
            div_num = {seed_prod_ff, 2'b0};
            div_bits = 6'd38;
         end
         wom_pkg::DIV_PMOD: begin
            div_num = {acc_ff, 22'b0};
            div_bits = 6'd18;
         end
         wom_pkg::DIV_STEP: begin
            div_num = {tone_freq_ff, 23'b0};
            div_bits = 6'd17;
         end
         default: begin
            div_num = {p_ff, 22'b0};
            div_bits = 6'd35;
         end
      endcase
   end

   wom_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .bits  (div_bits),
      .den   (rate),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   assign sine_idx = q_ff[16:7];
   assign tab_addr = sine_idx[wom_pkg::SINE_IDX_W]
      ? 9'(wom_pkg::SINE_ENTRIES - int'(sine_idx[wom_pkg::SINE_IDX_W-1:0]))
      : {1'b0, sine_idx[wom_pkg::SINE_IDX_W-1:0]};
   assign saw_q = q_ff[16:1];

   always_comb begin
      mag_in = '0;
      neg_in = 1'b0;
      case (waveform_ff)
         wom_pkg::WAVE_SINE: begin
            neg_in = sine_idx[wom_pkg::SINE_IDX_W+1];
         end
         wom_pkg::WAVE_SAW: begin
            if (saw_q[15]) begin
               mag_in = {1'b0, saw_q[14:0]};
            end else begin
               mag_in = 16'(17'd32768 - {1'b0, saw_q});
               neg_in = 1'b1;
            end
         end
         wom_pkg::WAVE_TRIANGLE: begin
            if (!q_ff[16]) begin
               if (q_ff[15]) begin
                  mag_in = {1'b0, q_ff[14:0]};
               end else begin
                  mag_in = 16'(17'd32768 - q_ff);
                  neg_in = 1'b1;
               end
            end else if (q_ff <= 17'd98304) begin
               mag_in = 16'(17'd98304 - q_ff);
            end else begin
               mag_in = 16'(q_ff - 17'd98304);
               neg_in = 1'b1;
            end
         end
         default: begin
            mag_in = 16'd32768;
            neg_in = q_ff[16];
         end
      endcase
   end

   assign mag_sel = (waveform_ff == wom_pkg::WAVE_SINE) ? {1'b0, tab_ff} : mag_ff;
   assign amp_mag = mul2_ff[45:29];
   assign amp = neg_ff ? -signed'({1'b0, amp_mag}) : signed'({1'b0, amp_mag});
   assign next_p = {1'b0, p_ff} + {2'b0, step_ff};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.div_load && cmd.div_op == wom_pkg::DIV_SEED) begin
         acc_in = div_rem;
      end else if (cmd.emit) begin
         acc_in = (next_p >= {1'b0, rate}) ? 18'(next_p - {1'b0, rate}) : next_p[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_ff <= wom_pkg::WAVE_SINE;
         sample_rate_ff <= 18'd44100;
         tone_freq_ff <= 17'd440;
         phase_offset_ff <= '0;
         start_offset_ff <= '0;
         volume_ff <= 15'd16384;
      end else if (csr_wr_en) begin
         case (csr_index)
            wom_pkg::CSR_WAVEFORM:     waveform_ff <= csr_data[1:0];
            wom_pkg::CSR_SAMPLE_RATE:  sample_rate_ff <= csr_data[17:0];
            wom_pkg::CSR_TONE_FREQ:    tone_freq_ff <= csr_data[16:0];
            wom_pkg::CSR_PHASE_OFFSET: phase_offset_ff <= csr_data;
            wom_pkg::CSR_START_OFFSET: start_offset_ff <= csr_data;
            wom_pkg::CSR_VOLUME:       volume_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         needs_seed_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (cmd.div_load && cmd.div_op == wom_pkg::DIV_SEED) begin
            needs_seed_ff <= 1'b0;
         end else if (cmd.emit) begin
            needs_seed_ff <= last_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mix_ff <= req_mix_sample;
         last_ff <= req_last_of_block;
      end
      if (cmd.seed_mul) begin
         seed_prod_ff <= 38'({1'b0, start_offset_ff} + {1'b0, phase_offset_ff}) * 38'(tone_freq_ff);
      end
      if (cmd.div_load && cmd.div_op == wom_pkg::DIV_PMOD) begin
         p_ff <= div_rem;
      end
      if (cmd.div_load && cmd.div_op == wom_pkg::DIV_STEP) begin
         step_ff <= div_rem[16:0];
      end
      if (cmd.div_load && cmd.div_op == wom_pkg::DIV_WAVE) begin
         q_ff <= div_quo[16:0];
      end
      if (cmd.shape) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         tab_ff <= QTAB[tab_addr];
      end
      if (cmd.mul1) begin
         mul1_ff <= 31'(mag_sel) * 31'(SCALE);
      end
      if (cmd.mul2) begin
         mul2_ff <= 46'(mul1_ff) * 46'(volume_ff);
      end
      if (cmd.emit) begin
         out_sample_ff <= 16'(18'(mix_ff) + amp);
         out_last_ff <= last_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.needs_seed = needs_seed_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_out_last = out_last_ff;

endmodule

// ===== src/wom_ctrl.sv =====
module wom_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wom_pkg::status_type status,
   output wom_pkg::cmd_type    cmd
);

   wom_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wom_pkg::ST_IDLE:
            if (req_valid) begin
               state_in = status.needs_seed ? wom_pkg::ST_SEED_MUL : wom_pkg::ST_PMOD_GO;
            end
         wom_pkg::ST_SEED_MUL:  state_in = wom_pkg::ST_SEED_GO;
         wom_pkg::ST_SEED_GO:   state_in = wom_pkg::ST_SEED_WAIT;
         wom_pkg::ST_SEED_WAIT: if (status.div_done) state_in = wom_pkg::ST_PMOD_GO;
         wom_pkg::ST_PMOD_GO:   state_in = wom_pkg::ST_PMOD_WAIT;
         wom_pkg::ST_PMOD_WAIT: if (status.div_done) state_in = wom_pkg::ST_STEP_GO;
         wom_pkg::ST_STEP_GO:   state_in = wom_pkg::ST_STEP_WAIT;
         wom_pkg::ST_STEP_WAIT: if (status.div_done) state_in = wom_pkg::ST_WAVE_GO;
         wom_pkg::ST_WAVE_GO:   state_in = wom_pkg::ST_WAVE_WAIT;
         wom_pkg::ST_WAVE_WAIT: if (status.div_done) state_in = wom_pkg::ST_SHAPE;
         wom_pkg::ST_SHAPE:     state_in = wom_pkg::ST_MUL1;
         wom_pkg::ST_MUL1:      state_in = wom_pkg::ST_MUL2;
         wom_pkg::ST_MUL2:      state_in = wom_pkg::ST_EMIT;
         wom_pkg::ST_EMIT:      if (status.out_free) state_in = wom_pkg::ST_IDLE;
         default:               state_in = wom_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_op = wom_pkg::DIV_WAVE;
      req_stall = 1'b1;
      case (state_ff)
         wom_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.accept = req_valid;
         end
         wom_pkg::ST_SEED_MUL: cmd.seed_mul = 1'b1;
         wom_pkg::ST_SEED_GO: begin
            cmd.div_op = wom_pkg::DIV_SEED;
            cmd.div_start = 1'b1;
         end
         wom_pkg::ST_SEED_WAIT: begin
            cmd.div_op = wom_pkg::DIV_SEED;
            cmd.div_load = status.div_done;
         end
         wom_pkg::ST_PMOD_GO: begin
            cmd.div_op = wom_pkg::DIV_PMOD;
            cmd.div_start = 1'b1;
         end
         wom_pkg::ST_PMOD_WAIT: begin
            cmd.div_op = wom_pkg::DIV_PMOD;
            cmd.div_load = status.div_done;
         end
         wom_pkg::ST_STEP_GO: begin
            cmd.div_op = wom_pkg::DIV_STEP;
            cmd.div_start = 1'b1;
         end
         wom_pkg::ST_STEP_WAIT: begin
            cmd.div_op = wom_pkg::DIV_STEP;
            cmd.div_load = status.div_done;
         end
         wom_pkg::ST_WAVE_GO: cmd.div_start = 1'b1;
         wom_pkg::ST_WAVE_WAIT: cmd.div_load = status.div_done;
         wom_pkg::ST_SHAPE: cmd.shape = 1'b1;
         wom_pkg::ST_MUL1: cmd.mul1 = 1'b1;
         wom_pkg::ST_MUL2: cmd.mul2 = 1'b1;
         wom_pkg::ST_EMIT: cmd.emit = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wom_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/waveform_oscillator_mixer.sv =====
// Adds one sample of a sine, sawtooth, triangle or square tone to each incoming 16-bit sample.
// Items are handled one at a time. The time per item is set by the single bit-serial divider,
// which runs three divisions per item (phase reduction, step, wave position), plus the phase
// seed at the start of a block, at one bit per cycle.
// A finished result waits in an output register, so the next item is taken while it is stalled;
// that item's result then waits for as long as the previous one is stalled.
// Configuration registers are written through csr_wr_en, csr_index and csr_data; the user must
// write them only while idle, as the block itself does not enforce this.
module waveform_oscillator_mixer #(
   parameter int AMPLITUDE_SCALE = 32000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_mix_sample,
   input  logic               req_last_of_block,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic               rsp_out_last
);

   wom_pkg::cmd_type    cmd;
   wom_pkg::status_type status;

   wom_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wom_datapath #(
      .AMPLITUDE_SCALE (AMPLITUDE_SCALE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_mix_sample    (req_mix_sample),
      .req_last_of_block (req_last_of_block),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_out_last      (rsp_out_last),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== src/wom_checker.sv =====
module wom_sva (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_sample,
   input logic        rsp_out_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_sample) && $stable(rsp_out_last))
      else $error("stalled result changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a second item without working on the first");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after an item");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind waveform_oscillator_mixer wom_sva u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_sample (rsp_out_sample),
   .rsp_out_last   (rsp_out_last)
);

// ===== bench/wom_checker.sv =====
`timescale 1ns / 1ps

module wom_checker #(
   parameter int AMPLITUDE_SCALE = 32000
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_mix_sample,
   input  logic               req_last_of_block,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_out_sample,
   input  logic               rsp_out_last,
   output int                 mismatch_count,
   output int                 samples_pending
);

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } mixed_item_type;

   mixed_item_type expected_mix[$];
   logic [14:0]    quarter_sine [0:wom_pkg::SINE_ENTRIES];

   wom_pkg::wave_type wave_shape;
   logic [17:0] rate;
   logic [16:0] tone;
   logic [19:0] phase_ofs;
   logic [19:0] start_ofs;
   logic [14:0] gain;
   logic [17:0] phase_acc;
   logic        reseed;

   initial begin
      logic [63:0] z, z2, term, divisor, v;
      longint      total;
      for (int k = 0; k <= wom_pkg::SINE_ENTRIES; k++) begin
         z = (64'(k) * wom_pkg::HALF_PI_Q30) / wom_pkg::SINE_ENTRIES;
         z2 = (z * z) >> 30;
         term = z;
         total = longint'(z);
         for (int n = 1; n <= 5; n++) begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term = ((term * z2) >> 30) / divisor;
            total = (n % 2 == 1) ? total - longint'(term) : total + longint'(term);
         end
         if (total < 0) begin
            total = 0;
         end
         v = (64'(total) * 64'd32767 + (64'd1 << 29)) >> 30;
         quarter_sine[k] = (v > 64'd32767) ? 15'd32767 : v[14:0];
      end
   end

   function automatic longint tone_level(logic [17:0] p, longint r);
      longint idx, m, u;
      case (wave_shape)
         wom_pkg::WAVE_SINE: begin
            idx = (longint'(p) * 4 * wom_pkg::SINE_ENTRIES) / r;
            m = idx % wom_pkg::SINE_ENTRIES;
            case ((idx / wom_pkg::SINE_ENTRIES) % 4)
               0: return longint'(quarter_sine[m]);
               1: return longint'(quarter_sine[wom_pkg::SINE_ENTRIES - m]);
               2: return -longint'(quarter_sine[m]);
               default: return -longint'(quarter_sine[wom_pkg::SINE_ENTRIES - m]);
            endcase
         end
         wom_pkg::WAVE_SAW: return (longint'(p) * 65536) / r - 32768;
         wom_pkg::WAVE_TRIANGLE: begin
            u = (longint'(p) * 131072) / r;
            return (u < 65536) ? u - 32768 : 98304 - u;
         end
         default: return (longint'(p) * 2 < r) ? 32768 : -32768;
      endcase
   endfunction

   function automatic mixed_item_type mix_tone(logic signed [15:0] mix, logic last);
      mixed_item_type res;
      longint r, p, prod, amp, total;
      r = (rate == 0) ? 1 : longint'(rate);
      if (reseed) begin
         phase_acc = 18'(((longint'(start_ofs) + longint'(phase_ofs)) * longint'(tone)) % r);
         reseed = 1'b0;
      end
      p = longint'(phase_acc) % r;
      prod = tone_level(18'(p), r) * AMPLITUDE_SCALE * longint'(gain);
      amp = (prod < 0) ? -((-prod) >>> 29) : (prod >>> 29);
      total = longint'(mix) + amp;
      res.sample = total[15:0];
      res.last = last;
      phase_acc = 18'((p + longint'(tone) % r) % r);
      if (last) begin
         reseed = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   assign samples_pending = expected_mix.size();

   always @(posedge clock) begin
      mixed_item_type want;
      if (reset) begin
         wave_shape = wom_pkg::WAVE_SINE;
         rate = 18'd44100;
         tone = 17'd440;
         phase_ofs = '0;
         start_ofs = '0;
         gain = 15'd16384;
         phase_acc = '0;
         reseed = 1'b1;
         expected_mix.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_mix.size() == 0) begin
               report_mismatch("unexpected sample", rsp_out_sample, 0);
            end else begin
               want = expected_mix.pop_front();
               if (rsp_out_sample !== want.sample) begin
                  report_mismatch("out_sample", rsp_out_sample, want.sample);
               end
               if (rsp_out_last !== want.last) begin
                  report_mismatch("out_last", rsp_out_last, want.last);
               end
            end
         end
         if (csr_wr_en) begin
            case (wom_pkg::csr_index_type'(csr_index))
               wom_pkg::CSR_WAVEFORM:     wave_shape = wom_pkg::wave_type'(csr_data[1:0]);
               wom_pkg::CSR_SAMPLE_RATE:  rate = csr_data[17:0];
               wom_pkg::CSR_TONE_FREQ:    tone = csr_data[16:0];
               wom_pkg::CSR_PHASE_OFFSET: phase_ofs = csr_data;
               wom_pkg::CSR_START_OFFSET: start_ofs = csr_data;
               wom_pkg::CSR_VOLUME:       gain = csr_data[14:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_mix.push_back(mix_tone(req_mix_sample, req_last_of_block));
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 400;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [19:0]        csr_data;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_mix_sample;
   logic               req_last_of_block;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_out_sample;
   logic               rsp_out_last;
   int                 mismatch_count;
   int                 samples_pending;
   int                 sender_idle_pct;
   int                 stall_pct;
   int                 hold_requests;
   int                 cycle_count;

   waveform_oscillator_mixer i_dut (.*);

   wom_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int holds_served;
      holds_served = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (1500) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(wom_pkg::csr_index_type idx, logic [19:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      while (samples_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_tone(wom_pkg::wave_type shape, logic [17:0] rate, logic [16:0] tone,
                            logic [19:0] phase_ofs, logic [19:0] start_ofs,
                            logic [14:0] gain);
      settle();
      write_reg(wom_pkg::CSR_WAVEFORM, 20'(shape));
      write_reg(wom_pkg::CSR_SAMPLE_RATE, 20'(rate));
      write_reg(wom_pkg::CSR_TONE_FREQ, 20'(tone));
      write_reg(wom_pkg::CSR_PHASE_OFFSET, phase_ofs);
      write_reg(wom_pkg::CSR_START_OFFSET, start_ofs);
      write_reg(wom_pkg::CSR_VOLUME, 20'(gain));
   endtask

   task automatic send_sample(logic signed [15:0] mix, logic last);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mix_sample <= mix;
      req_last_of_block <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) begin
         send_sample(16'($urandom), ($urandom_range(7) == 0));
      end
   endtask

   initial begin
      logic [17:0] rate;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_mix_sample = '0;
      req_last_of_block = 1'b0;
      sender_idle_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(-16'sd1, 1'b0);
      end_burst();
      for (int w = 0; w < 4; w++) begin
         load_tone(wom_pkg::wave_type'(w), 18'd8000, 17'd1000, 20'hfffff, 20'hfffff,
                   15'h7fff);
         send_sample(16'sh7fff, 1'b0);
         send_sample(-16'sd32768, 1'b0);
         send_sample(16'sh5555, 1'b0);
         send_sample(-16'sh2aab, 1'b1);
         end_burst();
      end
      load_tone(wom_pkg::WAVE_SAW, 18'd0, 17'd96000, 20'd5, 20'd3, 15'd0);
      send_sample(16'sd100, 1'b1);
      end_burst();
      load_tone(wom_pkg::WAVE_SQUARE, 18'd192000, 17'h1ffff, 20'd0, 20'd0, 15'd16384);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      end_burst();

      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 46; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 46; end
            default: begin sender_idle_pct = 14; stall_pct = 14; end
         endcase
         case (ph % 5)
            0: rate = 18'd8000;
            1: rate = 18'd192000;
            2: rate = 18'($urandom);
            3: rate = (ph == 3) ? 18'd0 : 18'h3ffff;
            default: rate = 18'($urandom_range(192000, 8000));
         endcase
         load_tone(wom_pkg::wave_type'($urandom_range(3)), rate,
                   (ph % 3 == 0) ? 17'($urandom) : 17'($urandom_range(rate / 2 + 1, 1)),
                   20'($urandom), 20'($urandom),
                   (ph % 4 == 0) ? 15'h7fff : 15'($urandom));
         send_random(40);
         if (ph == 5) begin
            hold_requests++;
         end
         if (ph == 7) begin
            end_burst();
            settle();
         end
         send_random(40);
         end_burst();
      end
      end_burst();
      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/wom_pkg.sv
src/wom_div.sv
src/wom_datapath.sv
src/wom_ctrl.sv
src/waveform_oscillator_mixer.sv
src/wom_checker.sv
bench/wom_checker.sv
bench/tb.sv
